FILE: hdl/ert_pkg.sv
// shared constants and types for the expiring ring table
package ert_pkg;
   localparam int RING_DEPTH_DEFAULT = 32;
   localparam logic [1:0] CMD_RECORD  = 2'd0;
   localparam logic [1:0] CMD_EXPIRE  = 2'd1;
   localparam logic [1:0] CMD_RESOLVE = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;
   localparam logic [1:0] ST_ACTIVE   = 2'd1;
   localparam logic [1:0] ST_EXPIRED  = 2'd2;
   localparam logic [1:0] ST_RESOLVED = 2'd3;
   localparam logic [9:0]  SCORE_MAX  = 10'd1000;
   localparam logic [15:0] TOPIC_NONE = 16'hFFFF;
   localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] actor;
      logic [15:0] topic;
      logic [15:0] speech_act;
      logic [15:0] urgency_in;
      logic [15:0] shame_in;
      logic [15:0] avoidance_in;
      logic [31:0] created_at;
      logic [31:0] expires_at;
      logic [31:0] now_turn;
      logic [1:0]  query_status;
   } req_type;

   typedef struct packed {
      logic [5:0]  changed_count;
      logic [5:0]  status_count;
      logic [5:0]  active_count;
      logic        latest_found;
      logic [31:0] latest_id;
      logic [31:0] latest_actor;
      logic [15:0] latest_topic;
      logic [15:0] latest_speech_act;
      logic [9:0]  latest_urgency;
      logic [31:0] latest_expiry;
      logic [31:0] records_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic record;    // write new entry
      logic scan_fwd;  // apply command at scan slot
      logic scan_cnt;  // count/search at scan slot
      logic clear;     // clear accumulators
      logic finish;    // latch result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic do_record;
      logic do_update;
      logic scan_last;
      logic empty;
   } sts_type;

   function automatic logic [9:0] sat_score(logic [15:0] v);
      return (v > 16'(SCORE_MAX)) ? SCORE_MAX : v[9:0];
   endfunction
endpackage

FILE: hdl/ert_if.sv
// valid/ready channel interface
interface ert_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ert_ctrl.sv
// controller state machine for the ring table
module ert_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   input  ert_pkg::sts_type sts,
   output ert_pkg::ctl_type ctl
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_CNT  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid && in_ready) begin
               ctl.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            ctl.clear = 1'b1;
            ctl.record = sts.do_record;
            if (sts.empty) state_in = S_DONE;
            else if (sts.do_update) state_in = S_UPD;
            else state_in = S_CNT;
         end
         S_UPD: begin
            ctl.scan_fwd = 1'b1;
            if (sts.scan_last) state_in = S_CNT;
         end
         S_CNT: begin
            ctl.scan_cnt = 1'b1;
            if (sts.scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!valid_ff || out_ready) begin
               ctl.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (ctl.finish) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

FILE: hdl/ert_data.sv
// datapath: entry memory, scan counter, accumulators and result register
module ert_data #(
   parameter int RING_DEPTH = ert_pkg::RING_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ert_pkg::req_type req,
   input  ert_pkg::ctl_type ctl,
   output ert_pkg::sts_type sts,
   output ert_pkg::rsp_type rsp
);
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] actor;
      logic [31:0] created;
      logic [31:0] expiry;
      logic [15:0] topic;
      logic [15:0] speech_act;
      logic [9:0]  urgency;
      logic [9:0]  shame;
      logic [9:0]  avoidance;
   } entry_type;

   entry_type  mem [RING_DEPTH];
   logic [1:0] stat_mem [RING_DEPTH];

   ert_pkg::req_type req_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] valid_ff;
   logic [31:0]   next_id_ff, total_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] step_ff;
   logic [5:0]    chg_ff, scnt_ff, acnt_ff;
   logic          found_ff;
   entry_type     best_ff;
   ert_pkg::rsp_type rsp_ff;
   logic [AW-1:0] head_nx;
   logic [31:0]   id_nx;
   logic          hit;
   logic [1:0]    st_new;
   entry_type     e;
   logic [1:0]    s;
   entry_type     new_entry;
   logic          wr_rec, wr_upd;
   entry_type     rd_entry_ff;
   logic [1:0]    rd_stat_ff;

   assign e = rd_entry_ff;
   assign s = rd_stat_ff;

   assign new_entry = '{id: next_id_ff, actor: req_ff.actor, created: req_ff.created_at,
      expiry: req_ff.expires_at, topic: req_ff.topic, speech_act: req_ff.speech_act,
      urgency: ert_pkg::sat_score(req_ff.urgency_in),
      shame: ert_pkg::sat_score(req_ff.shame_in),
      avoidance: ert_pkg::sat_score(req_ff.avoidance_in)};

   assign sts.do_record = (req_ff.cmd == ert_pkg::CMD_RECORD) &&
      (req_ff.topic != ert_pkg::TOPIC_NONE);
   assign sts.do_update = (req_ff.cmd == ert_pkg::CMD_EXPIRE) ||
      ((req_ff.cmd == ert_pkg::CMD_RESOLVE) && (req_ff.topic != ert_pkg::TOPIC_NONE));
   assign sts.empty     = (valid_ff == '0) && !sts.do_record;
   assign sts.scan_last = (step_ff == CW'(1));

   assign head_nx = (head_ff == LAST) ? '0 : head_ff + AW'(1);
   assign id_nx   = (next_id_ff == ert_pkg::U32_MAX) ? 32'd1 : next_id_ff + 32'd1;

   assign wr_rec = ctl.clear && ctl.record;
   assign wr_upd = ctl.scan_fwd && hit;

   // update rule for the slot under scan
   always_comb begin
      hit = 1'b0;
      st_new = ert_pkg::ST_EXPIRED;
      if (s == ert_pkg::ST_ACTIVE) begin
         if (req_ff.cmd == ert_pkg::CMD_EXPIRE) begin
            hit = (e.expiry != '0) && (req_ff.now_turn >= e.expiry);
         end else begin
            st_new = ert_pkg::ST_RESOLVED;
            hit = (e.created < req_ff.now_turn) && (e.topic == req_ff.topic) &&
                  ((e.actor == '0) || (req_ff.actor == '0) || (e.actor == req_ff.actor));
         end
      end
   end

   // scan index: update pass walks upwards, count pass walks back from head
   always_comb begin
      idx_in = idx_ff;
      if (ctl.clear) begin
         idx_in = sts.do_update ? '0 : ((head_ff == '0) ? LAST : head_ff - AW'(1));
         if (ctl.record) idx_in = head_ff;
      end else if (ctl.scan_fwd) begin
         idx_in = sts.scan_last ? ((head_ff == '0) ? LAST : head_ff - AW'(1)) : idx_ff + AW'(1);
      end else if (ctl.scan_cnt) begin
         idx_in = (idx_ff == '0) ? LAST : idx_ff - AW'(1);
      end
   end

   // entry memory writes and registered read of the next scan slot
   always_ff @(posedge clock) begin
      if (wr_rec) begin
         mem[head_ff]      <= new_entry;
         stat_mem[head_ff] <= ert_pkg::ST_ACTIVE;
      end else if (wr_upd) begin
         stat_mem[idx_ff] <= st_new;
      end
      // a write to the slot being read passes straight through
      rd_entry_ff <= (wr_rec && (head_ff == idx_in)) ? new_entry : mem[idx_in];
      if (wr_rec && (head_ff == idx_in)) rd_stat_ff <= ert_pkg::ST_ACTIVE;
      else if (wr_upd && (idx_ff == idx_in)) rd_stat_ff <= st_new;
      else rd_stat_ff <= stat_mem[idx_in];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         valid_ff   <= '0;
         next_id_ff <= 32'd1;
         total_ff   <= '0;
      end else if (wr_rec) begin
         head_ff    <= head_nx;
         next_id_ff <= id_nx;
         if (total_ff != ert_pkg::U32_MAX) total_ff <= total_ff + 32'd1;
         if (valid_ff != CW'(RING_DEPTH)) valid_ff <= valid_ff + CW'(1);
      end
   end

   // scan and accumulate
   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req;
      idx_ff <= idx_in;
      if (ctl.clear) begin
         chg_ff   <= '0;
         scnt_ff  <= '0;
         acnt_ff  <= '0;
         found_ff <= 1'b0;
         best_ff  <= '0;
         step_ff  <= (ctl.record && valid_ff != CW'(RING_DEPTH)) ? valid_ff + CW'(1) : valid_ff;
      end else if (ctl.scan_fwd) begin
         if (hit) chg_ff <= chg_ff + 6'd1;
         step_ff <= sts.scan_last ? valid_ff : step_ff - CW'(1);
      end else if (ctl.scan_cnt) begin
         if (s == req_ff.query_status) scnt_ff <= scnt_ff + 6'd1;
         if (s == ert_pkg::ST_ACTIVE) begin
            acnt_ff <= acnt_ff + 6'd1;
            if (!found_ff) begin
               found_ff <= 1'b1;
               best_ff  <= e;
            end
         end
         step_ff <= step_ff - CW'(1);
      end
      if (ctl.finish) begin
         rsp_ff <= '{changed_count: chg_ff, status_count: scnt_ff, active_count: acnt_ff,
            latest_found: found_ff, latest_id: best_ff.id, latest_actor: best_ff.actor,
            latest_topic: best_ff.topic, latest_speech_act: best_ff.speech_act,
            latest_urgency: best_ff.urgency, latest_expiry: best_ff.expiry,
            records_total: total_ff};
      end
   end

   assign rsp = rsp_ff;
endmodule

FILE: hdl/expiring_ring_table.sv
// top level of the expiring ring table
// One item at a time: each item runs a count and newest-active search over the valid
// entries, and expire, and resolve with a topic, first run an update pass over them;
// both passes go slot by slot through the single-port entry memory.
// The result sits in an output register, and the next item is taken while it waits;
// a finished item holds in the controller until that register is free.
module expiring_ring_table #(
   parameter int RING_DEPTH = ert_pkg::RING_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   ert_if.sink   req_ch,
   ert_if.source rsp_ch
);
   ert_pkg::ctl_type ctl;
   ert_pkg::sts_type sts;

   ert_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_ch.valid), .in_ready(req_ch.ready),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
      .sts(sts), .ctl(ctl)
   );

   ert_data #(.RING_DEPTH(RING_DEPTH)) u_data (
      .clock(clock), .reset(reset),
      .req(req_ch.data), .ctl(ctl), .sts(sts), .rsp(rsp_ch.data)
   );
endmodule

FILE: sim/ert_table_model.sv
`timescale 1ns / 1ps
// predictor and result checker for the expiring ring table
package ert_table_model;

   class ert_table_scoreboard;
      localparam int DEPTH = ert_pkg::RING_DEPTH_DEFAULT;
      logic [31:0] slot_id [DEPTH];
      logic [31:0] slot_actor [DEPTH];
      logic [31:0] slot_created [DEPTH];
      logic [31:0] slot_expiry [DEPTH];
      logic [15:0] slot_topic [DEPTH];
      logic [15:0] slot_speech [DEPTH];
      logic [9:0]  slot_urgency [DEPTH];
      logic [1:0]  slot_status [DEPTH];
      int unsigned head;
      int unsigned filled;
      logic [31:0] next_id;
      logic [31:0] total;
      ert_pkg::rsp_type pending_q [$];
      int          errors;
      int          checked;
      int          n_record, n_expire, n_resolve, n_query, n_changed;

      function new();
         head = 0;
         filled = 0;
         next_id = 1;
         total = 0;
         errors = 0;
         checked = 0;
         n_record = 0; n_expire = 0; n_resolve = 0; n_query = 0; n_changed = 0;
         for (int i = 0; i < DEPTH; i++) slot_status[i] = '0;
      endfunction

      function logic [9:0] clamp_score(logic [15:0] v);
         return (v > 16'd1000) ? 10'd1000 : v[9:0];
      endfunction

      // apply one command and queue the result it should give
      function void note_request(ert_pkg::req_type r);
         ert_pkg::rsp_type e;
         int unsigned changed, scount, acount, idx;
         changed = 0;
         scount = 0;
         acount = 0;
         e = '0;
         case (r.cmd)
            ert_pkg::CMD_RECORD: begin
               n_record++;
               if (r.topic != ert_pkg::TOPIC_NONE) begin
                  slot_id[head] = next_id;
                  next_id = next_id + 32'd1;
                  if (next_id == 32'd0) next_id = 32'd1;
                  slot_actor[head] = r.actor;
                  slot_created[head] = r.created_at;
                  slot_expiry[head] = r.expires_at;
                  slot_topic[head] = r.topic;
                  slot_speech[head] = r.speech_act;
                  slot_urgency[head] = clamp_score(r.urgency_in);
                  slot_status[head] = ert_pkg::ST_ACTIVE;
                  head = (head + 1 >= DEPTH) ? 0 : head + 1;
                  if (total != ert_pkg::U32_MAX) total++;
                  if (filled < DEPTH) filled++;
               end
            end
            ert_pkg::CMD_EXPIRE: begin
               n_expire++;
               for (int i = 0; i < filled; i++)
                  if (slot_status[i] == ert_pkg::ST_ACTIVE && slot_expiry[i] != 32'd0 &&
                      r.now_turn >= slot_expiry[i]) begin
                     slot_status[i] = ert_pkg::ST_EXPIRED;
                     changed++;
                  end
            end
            ert_pkg::CMD_RESOLVE: begin
               n_resolve++;
               if (r.topic != ert_pkg::TOPIC_NONE)
                  for (int i = 0; i < filled; i++)
                     if (slot_status[i] == ert_pkg::ST_ACTIVE &&
                         slot_created[i] < r.now_turn &&
                         slot_topic[i] == r.topic &&
                         (slot_actor[i] == 32'd0 || r.actor == 32'd0 ||
                          slot_actor[i] == r.actor)) begin
                        slot_status[i] = ert_pkg::ST_RESOLVED;
                        changed++;
                     end
            end
            default: n_query++;
         endcase
         if (changed != 0) n_changed++;
         for (int i = 0; i < filled; i++) begin
            if (slot_status[i] == r.query_status) scount++;
            if (slot_status[i] == ert_pkg::ST_ACTIVE) acount++;
         end
         e.changed_count = changed[5:0];
         e.status_count = scount[5:0];
         e.active_count = acount[5:0];
         // newest active entry, searching back from the head
         for (int s = 0; s < filled; s++) begin
            idx = (head + DEPTH - 1 - s) % DEPTH;
            if (slot_status[idx] == ert_pkg::ST_ACTIVE) begin
               e.latest_found = 1'b1;
               e.latest_id = slot_id[idx];
               e.latest_actor = slot_actor[idx];
               e.latest_topic = slot_topic[idx];
               e.latest_speech_act = slot_speech[idx];
               e.latest_urgency = slot_urgency[idx];
               e.latest_expiry = slot_expiry[idx];
               break;
            end
         end
         e.records_total = total;
         pending_q.push_back(e);
      endfunction

      function void report_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // compare one result with the oldest expectation
      function void check_result(ert_pkg::rsp_type a);
         ert_pkg::rsp_type e;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, a);
            return;
         end
         e = pending_q.pop_front();
         checked++;
         report_field("changed_count", 32'(e.changed_count), 32'(a.changed_count));
         report_field("status_count", 32'(e.status_count), 32'(a.status_count));
         report_field("active_count", 32'(e.active_count), 32'(a.active_count));
         report_field("latest_found", 32'(e.latest_found), 32'(a.latest_found));
         report_field("latest_id", e.latest_id, a.latest_id);
         report_field("latest_actor", e.latest_actor, a.latest_actor);
         report_field("latest_topic", 32'(e.latest_topic), 32'(a.latest_topic));
         report_field("latest_speech_act", 32'(e.latest_speech_act),
                      32'(a.latest_speech_act));
         report_field("latest_urgency", 32'(e.latest_urgency), 32'(a.latest_urgency));
         report_field("latest_expiry", e.latest_expiry, a.latest_expiry);
         report_field("records_total", e.records_total, a.records_total);
      endfunction
   endclass
endpackage

FILE: sim/expiring_ring_table_test.sv
`timescale 1ns / 1ps
// stimulus, handshake driving and end-of-run checks for the expiring ring table
module expiring_ring_table_test;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   ert_if #(.T(ert_pkg::req_type)) req_ch ();
   ert_if #(.T(ert_pkg::rsp_type)) rsp_ch ();

   expiring_ring_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   ert_table_model::ert_table_scoreboard board;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off;
   int quiet_cycles;
   int random_sent;
   logic [31:0] turn_now;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
             board.pending_q.size() == 0 && !req_ch.valid)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("expiring_ring_table regression: fail");
            $finish;
         end
      end
   end

   // offer one item and wait until it is taken; valid stays up for a following item
   task automatic send_item(ert_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   function automatic logic [15:0] pick_score();
      case ($urandom_range(4))
         0: return 16'd1000;
         1: return 16'd1001;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1200));
      endcase
   endfunction

   // random command, mostly well formed around a moving turn counter
   function automatic ert_pkg::req_type make_item();
      ert_pkg::req_type r;
      r = '0;
      r.actor = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(3));
      r.topic = ($urandom_range(15) == 0) ?
                ($urandom_range(1) ? ert_pkg::TOPIC_NONE : 16'($urandom()))
                : 16'($urandom_range(4));
      r.speech_act = 16'($urandom());
      r.urgency_in = pick_score();
      r.shame_in = pick_score();
      r.avoidance_in = pick_score();
      r.query_status = 2'($urandom_range(3));
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            r.cmd = ert_pkg::CMD_RECORD;
            turn_now = turn_now + $urandom_range(3);
            r.created_at = ($urandom_range(15) == 0) ? $urandom() : turn_now;
            r.expires_at = ($urandom_range(3) == 0) ? 32'd0 :
                           ($urandom_range(15) == 0) ? $urandom() :
                           turn_now + $urandom_range(20);
         end
         4, 5: r.cmd = ert_pkg::CMD_EXPIRE;
         6, 7: r.cmd = ert_pkg::CMD_RESOLVE;
         default: r.cmd = ert_pkg::CMD_QUERY;
      endcase
      r.now_turn = ($urandom_range(15) == 0) ? $urandom() : turn_now + $urandom_range(8);
      if ($urandom_range(31) == 0) begin
         r.created_at = $urandom();
         r.expires_at = $urandom();
      end
      return r;
   endfunction

   function automatic ert_pkg::req_type directed(logic [1:0] c, logic [31:0] act,
                                                 logic [15:0] top, logic [31:0] cre,
                                                 logic [31:0] exp_t, logic [31:0] now_t,
                                                 logic [1:0] qs);
      ert_pkg::req_type r;
      r = '0;
      r.cmd = c;
      r.actor = act;
      r.topic = top;
      r.speech_act = ~top;
      r.urgency_in = 16'hFFFF;
      r.shame_in = 16'd1000;
      r.avoidance_in = 16'd999;
      r.created_at = cre;
      r.expires_at = exp_t;
      r.now_turn = now_t;
      r.query_status = qs;
      return r;
   endfunction

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         send_item(make_item());
         random_sent++;
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_sent = 0;
      turn_now = 32'd100;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, ignored topic, wildcard actor, all queries
      send_item(directed(ert_pkg::CMD_QUERY, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 2'd0));
      send_item(directed(ert_pkg::CMD_EXPIRE, 32'd0, 16'd0, 32'd0, 32'd0,
                         32'hFFFF_FFFF, 2'd1));
      send_item(directed(ert_pkg::CMD_RECORD, 32'hFFFF_FFFF, ert_pkg::TOPIC_NONE,
                         32'd1, 32'd2, 32'd3, 2'd1));
      send_item(directed(ert_pkg::CMD_RECORD, 32'hFFFF_FFFF, 16'hFFFE, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'd0, 2'd1));
      send_item(directed(ert_pkg::CMD_RECORD, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 2'd0));
      send_item(directed(ert_pkg::CMD_RECORD, 32'd7, 16'd5, 32'd10, 32'd20, 32'd0, 2'd1));
      send_item(directed(ert_pkg::CMD_RECORD, 32'd8, 16'd5, 32'd10, 32'd30, 32'd0, 2'd1));
      send_item(directed(ert_pkg::CMD_EXPIRE, 32'd0, 16'd0, 32'd0, 32'd0, 32'd19, 2'd2));
      send_item(directed(ert_pkg::CMD_EXPIRE, 32'd0, 16'd0, 32'd0, 32'd0, 32'd20, 2'd2));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'd9, 16'd5, 32'd0, 32'd0, 32'd11, 2'd3));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'd0, 16'd5, 32'd0, 32'd0, 32'd10, 2'd3));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'd0, 16'd5, 32'd0, 32'd0, 32'd11, 2'd3));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'd0, ert_pkg::TOPIC_NONE, 32'd0, 32'd0,
                         32'hFFFF_FFFF, 2'd3));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'd5, 16'd0, 32'd0, 32'd0, 32'd1, 2'd3));
      send_item(directed(ert_pkg::CMD_RESOLVE, 32'hFFFF_FFFF, 16'hFFFE, 32'd0, 32'd0,
                         32'hFFFF_FFFF, 2'd3));
      send_item(directed(ert_pkg::CMD_EXPIRE, 32'd0, 16'd0, 32'd0, 32'd0,
                         32'hFFFF_FFFF, 2'd2));
      send_item(directed(ert_pkg::CMD_QUERY, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 2'd1));
      send_item(directed(ert_pkg::CMD_QUERY, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 2'd2));
      send_item(directed(ert_pkg::CMD_QUERY, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 2'd3));

      // fill the ring past its depth with a receiver hold-off
      fork
         begin
            hold_off = 1'b1;
            for (int c = 0; c < 400; c++) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 40; i++)
            send_item(directed(ert_pkg::CMD_RECORD, 32'(i), 16'(i), 32'd0, 32'(i),
                               32'd0, 2'd1));
      join

      run_phase(500, 0, 0);
      run_phase(450, 57, 0);
      run_phase(450, 0, 57);
      run_phase(450, 29, 29);
      req_ch.valid <= 1'b0;

      // drain
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d records, %0d expires, %0d resolves, %0d queries;",
               board.n_record, board.n_expire, board.n_resolve, board.n_query);
      $display("%0d results checked, %0d changed entries, ring wrapped under back-pressure",
               board.checked, board.n_changed);
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("expiring_ring_table regression: pass");
      else
         $display("expiring_ring_table regression: fail");
      $finish;
   end
endmodule
